>>> rtl/mffd_pkg.sv
package mffd_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned NUM_IDS       = 4;
   localparam int unsigned PAYLOAD_BYTES = 9;
   localparam int unsigned CSR_IDX_W     = 3;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
   localparam logic [BYTE_W-1:0] ID_MIN   = 8'd1;
   localparam logic [BYTE_W-1:0] ID_MAX   = 8'd253;

   localparam logic [CSR_IDX_W-1:0] REG_ID_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOWED_ID_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOWED_ID_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOWED_ID_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ALLOWED_ID_3 = 3'd4;

   localparam int unsigned BYTE_ID      = 0;
   localparam int unsigned BYTE_MODE    = 1;
   localparam int unsigned BYTE_CUR_HI  = 2;
   localparam int unsigned BYTE_CUR_LO  = 3;
   localparam int unsigned BYTE_VEL_HI  = 4;
   localparam int unsigned BYTE_VEL_LO  = 5;
   localparam int unsigned BYTE_POS_HI  = 6;
   localparam int unsigned BYTE_POS_LO  = 7;
   localparam int unsigned BYTE_FAULT   = 8;

   localparam logic [BYTE_W-1:0] FAULT_OVER_TEMP    = 8'h01;
   localparam logic [BYTE_W-1:0] FAULT_VOLTAGE      = 8'h02;
   localparam logic [BYTE_W-1:0] FAULT_OVER_CURRENT = 8'h04;
   localparam logic [BYTE_W-1:0] FAULT_SENSOR       = 8'h08;
   localparam logic [BYTE_W-1:0] FAULT_STALL        = 8'h10;
   localparam logic [BYTE_W-1:0] FAULT_INIT         = 8'h20;

   typedef struct packed {
      logic [2:0]                          id_count;
      logic [NUM_IDS-1:0][BYTE_W-1:0]      allowed_id;
   } id_cfg_type;

   typedef struct packed {
      logic                                hit;
      logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] data;
   } frame_type;

   // CRC contribution of one input bit that still has nbytes byte steps to go.
   function automatic logic [BYTE_W-1:0] crc_mask(input int unsigned nbytes,
                                                  input int unsigned bit_pos);
      logic [BYTE_W-1:0] c;
      c = BYTE_W'(1) << bit_pos;
      for (int unsigned s = 0; s < nbytes * BYTE_W; s++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/mffd_req_if.sv
interface mffd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/mffd_rsp_if.sv
interface mffd_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         drive_id;
   logic [7:0]         mode;
   logic signed [15:0] current_raw;
   logic signed [15:0] velocity_raw;
   logic [15:0]        position_raw;
   logic [7:0]         fault_bits;
   logic               temp_alarm;
   logic               supply_alarm;
   logic               amp_alarm;
   logic               encoder_alarm;
   logic               stalling;
   logic               boot_alarm;

   modport source (output valid, output drive_id, output mode, output current_raw,
                   output velocity_raw, output position_raw, output fault_bits,
                   output temp_alarm, output supply_alarm, output amp_alarm,
                   output encoder_alarm, output stalling, output boot_alarm,
                   input ready);
   modport sink   (input valid, input drive_id, input mode, input current_raw,
                   input velocity_raw, input position_raw, input fault_bits,
                   input temp_alarm, input supply_alarm, input amp_alarm,
                   input encoder_alarm, input stalling, input boot_alarm,
                   output ready);
endinterface

>>> rtl/mffd_csr.sv
module mffd_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [7:0]            csr_wdata,
   output mffd_pkg::id_cfg_type  cfg
);

   mffd_pkg::id_cfg_type cfg_ff;
   mffd_pkg::id_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mffd_pkg::REG_ID_COUNT:     cfg_in.id_count      = csr_wdata[2:0];
            mffd_pkg::REG_ALLOWED_ID_0: cfg_in.allowed_id[0] = csr_wdata;
            mffd_pkg::REG_ALLOWED_ID_1: cfg_in.allowed_id[1] = csr_wdata;
            mffd_pkg::REG_ALLOWED_ID_2: cfg_in.allowed_id[2] = csr_wdata;
            mffd_pkg::REG_ALLOWED_ID_3: cfg_in.allowed_id[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/mffd_window.sv
module mffd_window #(
   parameter int unsigned FRAME_LEN = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  mffd_pkg::id_cfg_type cfg,
   output mffd_pkg::frame_type  frame
);

   // Only FRAME_LEN-1 bytes are held; the closing CRC byte is the incoming beat.
   localparam int unsigned DEPTH  = FRAME_LEN - 1;
   localparam int unsigned FILL_W = $clog2(FRAME_LEN);

   logic [7:0]        win_ff  [DEPTH];
   logic [7:0]        win_in  [DEPTH];
   logic [7:0]        shifted [DEPTH];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [7:0]        term    [DEPTH][8];
   logic [7:0]        crc;
   logic              full;
   logic              id_listed;
   logic              id_ok;
   logic              hit;

   genvar gi, gj;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_lane
         for (gj = 0; gj < 8; gj++) begin : g_bit
            localparam logic [7:0] MASK = mffd_pkg::crc_mask(DEPTH - gi, gj);
            assign term[gi][gj] = win_ff[gi][gj] ? MASK : 8'h00;
         end
         if (gi < DEPTH - 1) begin : g_shift
            assign shifted[gi] = win_ff[gi+1];
         end else begin : g_tail
            assign shifted[gi] = rx_byte;
         end
      end
      for (gi = 0; gi < mffd_pkg::PAYLOAD_BYTES; gi++) begin : g_out
         if (gi < DEPTH) begin : g_held
            assign frame.data[gi] = win_ff[gi];
         end else begin : g_zero
            assign frame.data[gi] = 8'h00;
         end
      end
   endgenerate

   always_comb begin
      crc = 8'h00;
      for (int unsigned i = 0; i < DEPTH; i++) begin
         for (int unsigned j = 0; j < 8; j++) begin
            crc = crc ^ term[i][j];
         end
      end
   end

   always_comb begin
      id_listed = 1'b0;
      for (int unsigned i = 0; i < mffd_pkg::NUM_IDS; i++) begin
         if (cfg.id_count > 3'(i) && cfg.allowed_id[i] == win_ff[0]) begin
            id_listed = 1'b1;
         end
      end
   end

   assign id_ok = (cfg.id_count == 3'd0)
                  ? (win_ff[0] >= mffd_pkg::ID_MIN && win_ff[0] <= mffd_pkg::ID_MAX)
                  : id_listed;

   assign full = (fill_ff == FILL_W'(DEPTH));
   assign hit  = accept && full && id_ok && (crc == rx_byte);

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (!full) begin
            for (int unsigned i = 0; i < DEPTH; i++) begin
               if (fill_ff == FILL_W'(i)) begin
                  win_in[i] = rx_byte;
               end
            end
            fill_in = fill_ff + FILL_W'(1);
         end else if (hit) begin
            fill_in = '0;
         end else begin
            win_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign frame.hit = hit;

endmodule

>>> rtl/mffd_out_reg.sv
module mffd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  mffd_pkg::frame_type frame,
   output logic                slot_free,
   mffd_rsp_if.source          rsp
);

   logic                                                   valid_ff;
   logic                                                   valid_in;
   logic [mffd_pkg::PAYLOAD_BYTES-1:0][mffd_pkg::BYTE_W-1:0] data_ff;
   logic [7:0]                                             fault;

   assign slot_free = !valid_ff || rsp.ready;
   assign valid_in  = frame.hit || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.hit) begin
         data_ff <= frame.data;
      end
   end

   assign fault = data_ff[mffd_pkg::BYTE_FAULT];

   assign rsp.valid        = valid_ff;
   assign rsp.drive_id     = data_ff[mffd_pkg::BYTE_ID];
   assign rsp.mode         = data_ff[mffd_pkg::BYTE_MODE];
   assign rsp.current_raw  = signed'({data_ff[mffd_pkg::BYTE_CUR_HI],
                                      data_ff[mffd_pkg::BYTE_CUR_LO]});
   assign rsp.velocity_raw = signed'({data_ff[mffd_pkg::BYTE_VEL_HI],
                                      data_ff[mffd_pkg::BYTE_VEL_LO]});
   assign rsp.position_raw = {data_ff[mffd_pkg::BYTE_POS_HI],
                              data_ff[mffd_pkg::BYTE_POS_LO]};
   assign rsp.fault_bits   = fault;

   assign rsp.temp_alarm    = |(fault & mffd_pkg::FAULT_OVER_TEMP);
   assign rsp.supply_alarm  = |(fault & mffd_pkg::FAULT_VOLTAGE);
   assign rsp.amp_alarm     = |(fault & mffd_pkg::FAULT_OVER_CURRENT);
   assign rsp.encoder_alarm = |(fault & mffd_pkg::FAULT_SENSOR);
   assign rsp.stalling      = |(fault & mffd_pkg::FAULT_STALL);
   assign rsp.boot_alarm    = |(fault & mffd_pkg::FAULT_INIT);

endmodule

>>> rtl/motor_feedback_frame_deframer_top.sv
// Motor feedback deframer: takes one received byte per beat on req_ch, one byte per clock
// while req_ch.ready is high, and hunts for FRAME_LEN-byte frames whose first byte is an
// accepted motor ID (one of the first csr id_count registered IDs, or 1..253 when it is zero)
// and whose last byte equals the reflected CRC-8 (poly 0x8C, init 0) of the bytes before
// it. The CRC is a parallel XOR tree over the held window, so each byte is checked in the
// cycle it arrives. A matching frame yields one rsp_ch beat, registered, in the cycle after
// the closing byte is taken; the window then starts empty, otherwise the oldest byte drops
// out. req_ch.ready falls only while a result is held and rsp_ch.ready is low. There is no
// clearing pass after reset. Write the csr registers only while no byte is in flight.
module motor_feedback_frame_deframer_top #(
   parameter int unsigned FRAME_LEN = 10
) (
   input  logic        clock,
   input  logic        reset,
   mffd_req_if.sink    req_ch,
   mffd_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   mffd_pkg::id_cfg_type cfg;
   mffd_pkg::frame_type  frame;
   logic                 slot_free;
   logic                 req_accept;

   assign req_ch.ready = slot_free;
   assign req_accept   = req_ch.valid && slot_free;

   mffd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mffd_window #(
      .FRAME_LEN (FRAME_LEN)
   ) u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg),
      .frame   (frame)
   );

   mffd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .slot_free (slot_free),
      .rsp       (rsp_ch)
   );

   a_hit_on_beat: assert property (@(posedge clock) disable iff (reset)
      frame.hit |-> req_ch.valid && req_ch.ready)
      else $error("frame match without an accepted beat");

   a_hit_shows: assert property (@(posedge clock) disable iff (reset)
      frame.hit |=> rsp_ch.valid)
      else $error("frame match did not reach the result register");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !req_ch.ready)
      else $error("byte taken while a result is stalled");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.drive_id))
      else $error("stalled result lost or overwritten");

endmodule

>>> test/mffd_frame_checker.sv
`timescale 1ns / 100ps

package mffd_tb_pkg;

   // reflected CRC-8, LSB first, init 0, no final xor
   function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ mffd_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

module mffd_frame_checker #(
   parameter int unsigned FRAME_LEN = 10
) (
   input  logic       clock,
   input  logic       reset,
   mffd_req_if        req_mon,
   mffd_rsp_if        rsp_mon,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         fails,
   output int         pending,
   output int         decoded
);

   typedef struct {
      logic [7:0]         drive_id;
      logic [7:0]         mode;
      logic signed [15:0] current_raw;
      logic signed [15:0] velocity_raw;
      logic [15:0]        position_raw;
      logic [7:0]         fault_bits;
      logic               temp_alarm;
      logic               supply_alarm;
      logic               amp_alarm;
      logic               encoder_alarm;
      logic               stalling;
      logic               boot_alarm;
   } fb_frame_type;

   fb_frame_type frames_q[$];

   logic [7:0] window [FRAME_LEN];
   int         fill;
   logic [2:0] id_count;
   logic [7:0] allowed_id [mffd_pkg::NUM_IDS];
   int         mismatch_count = 0;
   int         beat_count = 0;

   assign fails   = mismatch_count;
   assign decoded = beat_count;

   task automatic report(input string msg);
      $display("%0t ns: ERROR: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
      end
   endtask

   function automatic bit id_accepted(input logic [7:0] id);
      int n;
      n = (id_count > mffd_pkg::NUM_IDS) ? mffd_pkg::NUM_IDS : id_count;
      if (n == 0) return (id >= mffd_pkg::ID_MIN) && (id <= mffd_pkg::ID_MAX);
      for (int i = 0; i < n; i++) begin
         if (allowed_id[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   // bytes at or past the crc position read as zero
   function automatic logic [7:0] field_byte(input int k);
      return (k < FRAME_LEN - 1) ? window[k] : 8'h00;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      fb_frame_type f;
      logic [7:0]   crc;
      logic [7:0]   e;
      if (fill < FRAME_LEN) window[fill] = b;
      fill++;
      if (fill < FRAME_LEN) return;
      crc = 8'h00;
      for (int k = 0; k < FRAME_LEN - 1; k++) begin
         crc = mffd_tb_pkg::crc8_maxim_step(crc, window[k]);
      end
      if (id_accepted(window[0]) && crc == window[FRAME_LEN-1]) begin
         e               = field_byte(mffd_pkg::BYTE_FAULT);
         f.drive_id      = field_byte(mffd_pkg::BYTE_ID);
         f.mode          = field_byte(mffd_pkg::BYTE_MODE);
         f.current_raw   = {field_byte(mffd_pkg::BYTE_CUR_HI),
                            field_byte(mffd_pkg::BYTE_CUR_LO)};
         f.velocity_raw  = {field_byte(mffd_pkg::BYTE_VEL_HI),
                            field_byte(mffd_pkg::BYTE_VEL_LO)};
         f.position_raw  = {field_byte(mffd_pkg::BYTE_POS_HI),
                            field_byte(mffd_pkg::BYTE_POS_LO)};
         f.fault_bits    = e;
         f.temp_alarm    = |(e & mffd_pkg::FAULT_OVER_TEMP);
         f.supply_alarm  = |(e & mffd_pkg::FAULT_VOLTAGE);
         f.amp_alarm     = |(e & mffd_pkg::FAULT_OVER_CURRENT);
         f.encoder_alarm = |(e & mffd_pkg::FAULT_SENSOR);
         f.stalling      = |(e & mffd_pkg::FAULT_STALL);
         f.boot_alarm    = |(e & mffd_pkg::FAULT_INIT);
         frames_q.insert(frames_q.size(), f);
         for (int k = 0; k < FRAME_LEN; k++) window[k] = 8'h00;
         fill = 0;
      end else begin
         for (int k = 0; k < FRAME_LEN - 1; k++) window[k] = window[k+1];
         window[FRAME_LEN-1] = 8'h00;
         fill = FRAME_LEN - 1;
      end
   endtask

   task automatic check_beat();
      fb_frame_type want;
      beat_count++;
      if (frames_q.size() == 0) begin
         report($sformatf("result beat with no frame pending, drive_id 0x%0h",
                          rsp_mon.drive_id));
         return;
      end
      want = frames_q.pop_front();
      compare_field("drive_id", rsp_mon.drive_id, want.drive_id);
      compare_field("mode", rsp_mon.mode, want.mode);
      compare_field("current_raw", rsp_mon.current_raw, want.current_raw);
      compare_field("velocity_raw", rsp_mon.velocity_raw, want.velocity_raw);
      compare_field("position_raw", rsp_mon.position_raw, want.position_raw);
      compare_field("fault_bits", rsp_mon.fault_bits, want.fault_bits);
      compare_field("temp_alarm", rsp_mon.temp_alarm, want.temp_alarm);
      compare_field("supply_alarm", rsp_mon.supply_alarm, want.supply_alarm);
      compare_field("amp_alarm", rsp_mon.amp_alarm, want.amp_alarm);
      compare_field("encoder_alarm", rsp_mon.encoder_alarm, want.encoder_alarm);
      compare_field("stalling", rsp_mon.stalling, want.stalling);
      compare_field("boot_alarm", rsp_mon.boot_alarm, want.boot_alarm);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAME_LEN; k++) window[k] = 8'h00;
         for (int i = 0; i < mffd_pkg::NUM_IDS; i++) allowed_id[i] = 8'h00;
         fill     = 0;
         id_count = 3'd0;
         frames_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               mffd_pkg::REG_ID_COUNT:     id_count      = csr_wdata[2:0];
               mffd_pkg::REG_ALLOWED_ID_0: allowed_id[0] = csr_wdata;
               mffd_pkg::REG_ALLOWED_ID_1: allowed_id[1] = csr_wdata;
               mffd_pkg::REG_ALLOWED_ID_2: allowed_id[2] = csr_wdata;
               mffd_pkg::REG_ALLOWED_ID_3: allowed_id[3] = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) check_beat();
      end
      pending = frames_q.size();
   end

endmodule

>>> test/motor_feedback_frame_deframer_top_tb.sv
`timescale 1ns / 100ps

module motor_feedback_frame_deframer_top_tb;

   localparam int unsigned FRAME_LEN      = 10;
   localparam int          NUM_SETTINGS   = 8;
   localparam int          PHASE_BYTES    = 80;
   localparam int          LONG_HOLD      = 200;
   localparam int          WATCHDOG_LIMIT = 3000;

   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   mffd_req_if req_ch ();
   mffd_rsp_if rsp_ch ();

   int fails;
   int pending;
   int decoded;

   int         bytes_sent = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         hold_req = 0;
   int         hold_ack = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   logic [2:0] cur_count = 3'd0;
   logic [7:0] id_table [mffd_pkg::NUM_IDS];

   always #1 clock = ~clock;

   motor_feedback_frame_deframer_top #(.FRAME_LEN(FRAME_LEN)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mffd_frame_checker #(.FRAME_LEN(FRAME_LEN)) i_checker (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fails     (fails),
      .pending   (pending),
      .decoded   (decoded)
   );

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack     <= hold_req;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog: no beat for %0d cycles, %0d frames outstanding",
                  $time, quiet_cycles, pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // payload is mode, current, velocity, position, fault, MSB first
   task automatic send_frame(input logic [7:0] id, input logic [63:0] payload,
                             input int len, input bit flip);
      logic [79:0] frame;
      logic [7:0]  crc;
      crc = mffd_tb_pkg::crc8_maxim_step(8'h00, id);
      for (int i = 0; i < 8; i++) begin
         crc = mffd_tb_pkg::crc8_maxim_step(crc, payload[63-8*i -: 8]);
      end
      frame = {id, payload, crc};
      if (flip) frame = frame ^ (80'd1 << $urandom_range(79));
      for (int i = 0; i < len; i++) begin
         send_byte(frame[79-8*i -: 8]);
      end
   endtask

   function automatic logic [7:0] pick_id();
      int n;
      n = (cur_count > mffd_pkg::NUM_IDS) ? mffd_pkg::NUM_IDS : cur_count;
      if ($urandom_range(99) < 15) return 8'($urandom_range(255));
      if (n == 0) return 8'($urandom_range(mffd_pkg::ID_MAX, mffd_pkg::ID_MIN));
      return id_table[$urandom_range(n - 1)];
   endfunction

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [2:0] idx, input logic [7:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_setting(input int p);
      logic [2:0] cnt;
      logic [7:0] ids [mffd_pkg::NUM_IDS];
      for (int i = 0; i < mffd_pkg::NUM_IDS; i++) ids[i] = 8'($urandom_range(255));
      case (p)
         0: cnt = 3'd0;
         1: begin
            cnt    = 3'd1;
            ids[0] = 8'h05;
         end
         2: begin
            cnt = 3'd4;
            ids[0] = 8'h00;
            ids[1] = 8'hFF;
            ids[2] = mffd_pkg::ID_MIN;
            ids[3] = mffd_pkg::ID_MAX;
         end
         3: cnt = 3'd7;
         4: begin
            cnt    = 3'd2;
            ids[0] = 8'h42;
            ids[1] = 8'h42;
         end
         5: cnt = 3'd3;
         6: begin
            cnt    = 3'd5;
            ids[0] = 8'hFE;
            ids[1] = 8'h00;
         end
         default: cnt = 3'd0;
      endcase
      csr_put(mffd_pkg::REG_ID_COUNT, {5'd0, cnt});
      csr_put(mffd_pkg::REG_ALLOWED_ID_0, ids[0]);
      csr_put(mffd_pkg::REG_ALLOWED_ID_1, ids[1]);
      csr_put(mffd_pkg::REG_ALLOWED_ID_2, ids[2]);
      csr_put(mffd_pkg::REG_ALLOWED_ID_3, ids[3]);
      // unmapped indexes must not disturb the ID list
      if (p == 3) csr_put(REG_SPARE_LO, 8'($urandom_range(255)));
      if (p == 6) csr_put(REG_SPARE_HI, 8'($urandom_range(255)));
      csr_we    <= 1'b0;
      cur_count  = cnt;
      for (int i = 0; i < mffd_pkg::NUM_IDS; i++) id_table[i] = ids[i];
   endtask

   task automatic run_traffic(input int nbytes);
      int stop_at;
      int roll;
      stop_at = bytes_sent + nbytes;
      while (bytes_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 65) send_frame(pick_id(), {$urandom, $urandom}, FRAME_LEN, 1'b0);
         else if (roll < 78) send_frame(pick_id(), {$urandom, $urandom}, FRAME_LEN, 1'b1);
         else if (roll < 88) send_frame(pick_id(), {$urandom, $urandom},
                                        $urandom_range(FRAME_LEN - 1, 1), 1'b0);
         else repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      csr_we         = 1'b0;
      csr_index      = mffd_pkg::REG_ID_COUNT;
      csr_wdata      = 8'h00;
      for (int i = 0; i < mffd_pkg::NUM_IDS; i++) id_table[i] = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes with the reset ID range
      send_frame(mffd_pkg::ID_MIN, {8'hFF, 16'h7FFF, 16'h8000, 16'hFFFF, 8'h3F},
                 FRAME_LEN, 1'b0);
      send_frame(mffd_pkg::ID_MAX, {8'h00, 16'h8000, 16'h7FFF, 16'h0000, 8'hC0},
                 FRAME_LEN, 1'b0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFE);
      send_byte(8'h01);
      send_byte(8'hAA);
      settle();

      // hold off the receiver while frames keep coming
      hold_req++;
      repeat (5) send_frame(pick_id() | 8'h01, {$urandom, $urandom}, FRAME_LEN, 1'b0);
      settle();

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         load_setting(p);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 61;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 61;
            end
            default: begin
               send_idle_pct = 19;
               stall_pct     = 19;
            end
         endcase
         run_traffic(PHASE_BYTES);
         settle();
      end

      repeat (10) @(posedge clock);
      $display("Ran %0d bytes through %0d ID list settings under idle, stall and hold-off.",
               bytes_sent, NUM_SETTINGS);
      $display("Checked %0d decoded frames.", decoded);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
